@@ hdl/signed_binary_to_decimal_ascii_defines.svh @@
// Assertion macros for the signed binary to decimal ASCII block.
// Used by the checker; no other dependencies.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// same-cycle implication
`define SBDA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SBDA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/sbda_pkg.sv @@
// Shared types and constants for the signed binary to decimal ASCII block.
// No dependencies.
package sbda_pkg;

   localparam int VALUE_W            = 64;
   localparam int CHAR_W             = 8;
   localparam int POS_W              = 5;
   localparam int DIGIT_W            = 4;
   localparam int MAX_DIGITS_DEFAULT = 20;

   localparam logic [POS_W-1:0]  WIDTH_RESET = 5'd20;
   localparam logic [CHAR_W-1:0] CH_ZERO     = 8'd48;
   localparam logic [CHAR_W-1:0] CH_MINUS    = 8'd45;
   localparam logic [CHAR_W-1:0] CH_SPACE    = 8'd32;

   typedef logic [DIGIT_W-1:0] digit_type;

   localparam digit_type DIGIT_ZERO = 4'd0;

   typedef enum logic [2:0] {
      CONV_EMPTY = 3'b001,
      CONV_BUSY  = 3'b010,
      CONV_DONE  = 3'b100
   } conv_state_type;

   typedef enum logic [2:0] {
      EMIT_IDLE = 3'b001,
      EMIT_SKIP = 3'b010,
      EMIT_SEND = 3'b100
   } emit_state_type;

   typedef struct packed {
      logic done;
      logic neg;
      logic ovf;
   } conv_status_type;

endpackage

@@ hdl/sbda_if.sv @@
// Channel interfaces: request, response and register write.
// Depends on sbda_pkg.
interface sbda_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [sbda_pkg::VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sbda_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sbda_pkg::CHAR_W-1:0] char_code;
   logic [sbda_pkg::POS_W-1:0]  position;
   logic                        last_char;

   modport source (output valid, output char_code, output position, output last_char,
                   input ready);
   modport sink   (input valid, input char_code, input position, input last_char,
                   output ready);
endinterface

interface sbda_csr_if;
   logic                       valid;
   logic                       ready;
   logic [sbda_pkg::POS_W-1:0] field_width;

   modport source (output valid, output field_width, input ready);
   modport sink   (input valid, input field_width, output ready);
endinterface

@@ hdl/sbda_bcd_cell.sv @@
// One BCD digit cell of the double dabble shift chain.
// Depends on sbda_pkg.
module sbda_bcd_cell (
   input  logic               clock,
   input  logic               clear,
   input  logic               shift,
   input  logic               shift_in,
   output sbda_pkg::digit_type digit,
   output logic               carry_out
);

   sbda_pkg::digit_type digit_ff;
   sbda_pkg::digit_type adj;

   always_comb begin
      if (digit_ff >= 4'd5) begin
         adj = digit_ff + 4'd3;
      end else begin
         adj = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         digit_ff <= sbda_pkg::DIGIT_ZERO;
      end else if (shift) begin
         digit_ff <= {adj[2:0], shift_in};
      end
   end

   assign digit     = digit_ff;
   assign carry_out = adj[3];

endmodule

@@ hdl/sbda_converter.sv @@
// Bit-serial binary to BCD converter: magnitude shifter and a chain of digit cells.
// Depends on sbda_pkg, sbda_if, sbda_bcd_cell.
module sbda_converter #(
   parameter int MAX_DIGITS = sbda_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   sbda_req_if.sink                             req,
   input  logic                                 take,
   output sbda_pkg::conv_status_type            status,
   output sbda_pkg::digit_type [MAX_DIGITS-1:0] digits
);

   localparam int CNT_W = $clog2(sbda_pkg::VALUE_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(sbda_pkg::VALUE_W - 1);

   sbda_pkg::conv_state_type state_ff, state_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [sbda_pkg::VALUE_W-1:0] mag_ff, mag_in;
   logic                         neg_ff, neg_in;
   logic                         ovf_ff, ovf_in;
   logic                         load;
   logic                         shift;
   logic [MAX_DIGITS-1:0]        carry;

   assign req.ready = (state_ff == sbda_pkg::CONV_EMPTY) ||
                      ((state_ff == sbda_pkg::CONV_DONE) && take);
   assign load  = req.valid && req.ready;
   assign shift = (state_ff == sbda_pkg::CONV_BUSY);

   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      if (i == 0) begin : g_first
         sbda_bcd_cell u_cell (
            .clock     (clock),
            .clear     (load),
            .shift     (shift),
            .shift_in  (mag_ff[sbda_pkg::VALUE_W-1]),
            .digit     (digits[i]),
            .carry_out (carry[i])
         );
      end else begin : g_rest
         sbda_bcd_cell u_cell (
            .clock     (clock),
            .clear     (load),
            .shift     (shift),
            .shift_in  (carry[i-1]),
            .digit     (digits[i]),
            .carry_out (carry[i])
         );
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbda_pkg::CONV_EMPTY: begin
            if (load) state_in = sbda_pkg::CONV_BUSY;
         end
         sbda_pkg::CONV_BUSY: begin
            if (cnt_ff == CNT_LAST) state_in = sbda_pkg::CONV_DONE;
         end
         sbda_pkg::CONV_DONE: begin
            if (load) begin
               state_in = sbda_pkg::CONV_BUSY;
            end else if (take) begin
               state_in = sbda_pkg::CONV_EMPTY;
            end
         end
         default: state_in = sbda_pkg::CONV_EMPTY;
      endcase
   end

   always_comb begin
      mag_in = mag_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      ovf_in = ovf_ff;
      if (load) begin
         neg_in = req.value[sbda_pkg::VALUE_W-1];
         if (req.value[sbda_pkg::VALUE_W-1]) begin
            mag_in = sbda_pkg::VALUE_W'(~req.value + 1'b1);
         end else begin
            mag_in = sbda_pkg::VALUE_W'(req.value);
         end
         cnt_in = '0;
         ovf_in = 1'b0;
      end else if (shift) begin
         mag_in = {mag_ff[sbda_pkg::VALUE_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         ovf_in = ovf_ff | carry[MAX_DIGITS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbda_pkg::CONV_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      ovf_ff <= ovf_in;
   end

   assign status.done = (state_ff == sbda_pkg::CONV_DONE);
   assign status.neg  = neg_ff;
   assign status.ovf  = ovf_ff;

endmodule

@@ hdl/sbda_emitter.sv @@
// Character emitter: digit shift chain, leading-zero and sign logic, response register.
// Depends on sbda_pkg, sbda_if.
module sbda_emitter #(
   parameter int MAX_DIGITS = sbda_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [sbda_pkg::POS_W-1:0]           width,
   input  sbda_pkg::conv_status_type            status,
   input  sbda_pkg::digit_type [MAX_DIGITS-1:0] digits,
   output logic                                 take,
   sbda_rsp_if.source                           rsp
);

   localparam int KW = $clog2(MAX_DIGITS);
   localparam logic [KW-1:0] K_TOP = KW'(MAX_DIGITS - 1);
   localparam logic [sbda_pkg::POS_W-1:0] MAX_W = sbda_pkg::POS_W'(MAX_DIGITS);

   sbda_pkg::emit_state_type              state_ff, state_in;
   sbda_pkg::digit_type [MAX_DIGITS-1:0]  dig_ff, dig_in;
   logic [KW-1:0]                         k_ff, k_in;
   logic                                  seen_ff, seen_in;
   logic                                  neg_ff, neg_in;
   logic                                  valid_ff;
   logic [sbda_pkg::CHAR_W-1:0]           char_ff, char_val;
   logic [sbda_pkg::POS_W-1:0]            pos_ff;
   logic                                  last_ff;
   logic [sbda_pkg::POS_W-1:0]            k5;
   sbda_pkg::digit_type                   top;
   sbda_pkg::digit_type                   nxt;
   logic                                  send_step;
   logic                                  advance;

   assign k5  = sbda_pkg::POS_W'(k_ff);
   assign top = dig_ff[MAX_DIGITS-1];
   assign nxt = dig_ff[MAX_DIGITS-2];

   assign send_step = (state_ff == sbda_pkg::EMIT_SEND) && (!valid_ff || rsp.ready);
   assign advance   = (state_ff == sbda_pkg::EMIT_SKIP) || send_step;
   assign take      = status.done && ((state_ff == sbda_pkg::EMIT_IDLE) ||
                                      (send_step && (k_ff == '0)));

   always_comb begin
      priority if (seen_ff || (top != sbda_pkg::DIGIT_ZERO)) begin
         char_val = sbda_pkg::CH_ZERO + sbda_pkg::CHAR_W'(top);
      end else if (k_ff == '0) begin
         char_val = sbda_pkg::CH_ZERO;
      end else if (neg_ff && (nxt != sbda_pkg::DIGIT_ZERO)) begin
         char_val = sbda_pkg::CH_MINUS;
      end else begin
         char_val = sbda_pkg::CH_SPACE;
      end
   end

   always_comb begin
      state_in = state_ff;
      dig_in   = dig_ff;
      k_in     = k_ff;
      seen_in  = seen_ff;
      neg_in   = neg_ff;
      if (advance) begin
         dig_in  = {dig_ff[MAX_DIGITS-2:0], sbda_pkg::DIGIT_ZERO};
         seen_in = seen_ff | (top != sbda_pkg::DIGIT_ZERO);
         k_in    = k_ff - 1'b1;
         unique case (state_ff)
            sbda_pkg::EMIT_SKIP: begin
               if (k5 == width) state_in = sbda_pkg::EMIT_SEND;
            end
            sbda_pkg::EMIT_SEND: begin
               if (k_ff == '0) state_in = sbda_pkg::EMIT_IDLE;
            end
            default: state_in = sbda_pkg::EMIT_IDLE;
         endcase
      end
      if (take) begin
         dig_in  = digits;
         seen_in = status.ovf;
         neg_in  = status.neg;
         k_in    = K_TOP;
         if (width == MAX_W) begin
            state_in = sbda_pkg::EMIT_SEND;
         end else begin
            state_in = sbda_pkg::EMIT_SKIP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbda_pkg::EMIT_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (send_step) begin
            valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      dig_ff  <= dig_in;
      k_ff    <= k_in;
      seen_ff <= seen_in;
      neg_ff  <= neg_in;
      if (send_step) begin
         char_ff <= char_val;
         pos_ff  <= width - 5'd1 - k5;
         last_ff <= (k_ff == '0);
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.char_code = char_ff;
   assign rsp.position  = pos_ff;
   assign rsp.last_char = last_ff;

endmodule

@@ hdl/signed_binary_to_decimal_ascii.sv @@
// Top level: signed 64-bit value to right-justified decimal ASCII field.
// Depends on sbda_pkg, sbda_if, sbda_converter, sbda_emitter.
//
//   channel   dir   payload              accepted when
//   req_bus   in    value[63:0] signed   valid & ready
//   rsp_bus   out   char_code, position, valid & ready
//                   last_char
//   csr_bus   in    field_width[4:0]     valid & ready (ready always high)
//
// A request is converted in the double dabble cell chain, one magnitude bit a
// cycle; the next request enters as the finished digits move to the emitter.
// The emitter skips the digits above the field width without output, then sends
// one character a cycle when not stalled, overlapped with the next conversion.
// Response stalls hold the emitter; the converter waits only when it is done.
// Synchronous reset clears control state; field width resets to 20.
module signed_binary_to_decimal_ascii #(
   parameter int MAX_DIGITS = sbda_pkg::MAX_DIGITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   sbda_req_if.sink   req_bus,
   sbda_rsp_if.source rsp_bus,
   sbda_csr_if.sink   csr_bus
);

   localparam logic [sbda_pkg::POS_W-1:0] MAX_W = sbda_pkg::POS_W'(MAX_DIGITS);

   logic [sbda_pkg::POS_W-1:0]           width_ff;
   logic [sbda_pkg::POS_W-1:0]           eff_width;
   logic                                 take;
   sbda_pkg::conv_status_type            status;
   sbda_pkg::digit_type [MAX_DIGITS-1:0] digits;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= sbda_pkg::WIDTH_RESET;
      end else if (csr_bus.valid) begin
         width_ff <= csr_bus.field_width;
      end
   end

   always_comb begin
      priority if (width_ff == '0) begin
         eff_width = 5'd1;
      end else if (width_ff > MAX_W) begin
         eff_width = MAX_W;
      end else begin
         eff_width = width_ff;
      end
   end

   sbda_converter #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_converter (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .take   (take),
      .status (status),
      .digits (digits)
   );

   sbda_emitter #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_emitter (
      .clock  (clock),
      .reset  (reset),
      .width  (eff_width),
      .status (status),
      .digits (digits),
      .take   (take),
      .rsp    (rsp_bus)
   );

endmodule

@@ hdl/sbda_checker.sv @@
// Port-level checks on the response channel, bound to the top level.
// Depends on sbda_pkg and signed_binary_to_decimal_ascii_defines.svh.
`include "signed_binary_to_decimal_ascii_defines.svh"

module sbda_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [sbda_pkg::CHAR_W-1:0] rsp_char_code,
   input logic [sbda_pkg::POS_W-1:0]  rsp_position,
   input logic                        rsp_last_char
);

   logic is_digit;

   assign is_digit = (rsp_char_code >= sbda_pkg::CH_ZERO) &&
                     (rsp_char_code <= sbda_pkg::CH_ZERO + 8'd9);

   `SBDA_ASSERT_IMP(a_char_legal, clock, reset, rsp_valid, is_digit || (rsp_char_code == sbda_pkg::CH_MINUS) || (rsp_char_code == sbda_pkg::CH_SPACE), "illegal character code")
   `SBDA_ASSERT_IMP(a_last_is_digit, clock, reset, rsp_valid && rsp_last_char, is_digit, "rightmost character is not a digit")
   `SBDA_ASSERT_IMP(a_reset_idle, clock, 1'b0, $past(reset), !rsp_valid, "response valid right after reset")
   `SBDA_ASSERT_NXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_char_code) && $stable(rsp_position) && $stable(rsp_last_char), "stalled response changed")

endmodule

bind signed_binary_to_decimal_ascii sbda_checker u_sbda_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_char_code (rsp_bus.char_code),
   .rsp_position  (rsp_bus.position),
   .rsp_last_char (rsp_bus.last_char)
);

@@ verif/signed_binary_to_decimal_ascii_tb.sv @@
`timescale 1ns / 1ps
// Testbench for signed_binary_to_decimal_ascii: random and directed 64-bit values
// checked char by char against an in-bench field predictor over many field widths.
// Depends on sbda_pkg, sbda_if and the RTL top level.
module signed_binary_to_decimal_ascii_tb;

   localparam int VALUE_W      = sbda_pkg::VALUE_W;
   localparam int CHAR_W       = sbda_pkg::CHAR_W;
   localparam int POS_W        = sbda_pkg::POS_W;
   localparam int MAX_DIGITS   = sbda_pkg::MAX_DIGITS_DEFAULT;
   localparam int IDLE_LIMIT   = 3000;
   localparam int HOLD_CYCLES  = 400;
   localparam int HOLD_AFTER   = 300;
   localparam int DRAIN_CYCLES = 150;
   localparam int PHASE_ITEMS  = 31;
   localparam int RANDOM_PHASES = 11;

   localparam logic [CHAR_W-1:0] CH_ZERO     = sbda_pkg::CH_ZERO;
   localparam logic [CHAR_W-1:0] CH_MINUS    = sbda_pkg::CH_MINUS;
   localparam logic [CHAR_W-1:0] CH_SPACE    = sbda_pkg::CH_SPACE;
   localparam logic [POS_W-1:0]  WIDTH_RESET = sbda_pkg::WIDTH_RESET;

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic [POS_W-1:0]  position;
      logic              last_char;
   } field_char_type;

   logic clock;
   logic reset;

   sbda_req_if req_bus ();
   sbda_rsp_if rsp_bus ();
   sbda_csr_if csr_bus ();

   signed_binary_to_decimal_ascii u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   logic signed [VALUE_W-1:0] pending_values[$];
   field_char_type            expected_chars[$];
   logic [POS_W-1:0]          width_setting = WIDTH_RESET;
   int                        requests_issued;
   int                        requests_taken = 0;
   int                        chars_received = 0;
   int                        mismatches = 0;
   int                        idle_cycles = 0;
   int                        tx_gap;
   int                        rx_gap;
   int                        hold_left;
   bit                        hold_done = 1'b0;
   bit                        tx_idle_on;
   bit                        rx_idle_on;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic int pick_gap(input bit idle_on);
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   // decimal field of one value, right justified, pushed as expected characters
   function automatic void render_field(input logic [VALUE_W-1:0] raw,
                                        input logic [POS_W-1:0] setting);
      logic [VALUE_W-1:0] mag;
      logic               sign_pending;
      logic [CHAR_W-1:0]  text [MAX_DIGITS];
      logic [3:0]         digit;
      int                 w;
      int                 p;
      mag          = raw[VALUE_W-1] ? (~raw + 64'd1) : raw;
      sign_pending = raw[VALUE_W-1];
      w            = (setting == 0) ? 1 : ((setting > MAX_DIGITS) ? MAX_DIGITS : setting);
      for (int k = 0; k < w; k++) begin
         p = w - 1 - k;
         if (mag == 0) begin
            if (k == 0) begin
               text[p] = CH_ZERO;
            end else if (sign_pending) begin
               text[p] = CH_MINUS;
               sign_pending = 1'b0;
            end else begin
               text[p] = CH_SPACE;
            end
         end else begin
            digit   = 4'(mag % 64'd10);
            text[p] = CH_ZERO + CHAR_W'(digit);
            mag     = mag / 64'd10;
         end
      end
      for (int k = 0; k < w; k++)
         expected_chars.push_back('{text[k], POS_W'(k), (k == w - 1)});
   endfunction

   function automatic logic signed [VALUE_W-1:0] random_value();
      logic signed [VALUE_W-1:0] v;
      int                        r;
      int                        delta;
      r = $urandom_range(0, 9);
      if (r < 3) begin
         v = {$urandom, $urandom};
      end else if (r < 5) begin
         v = $urandom_range(0, 999);
         if ($urandom_range(0, 1)) v = -v;
      end else if (r < 7) begin
         v = {$urandom, $urandom};
         v = v >>> 0;
         v = $unsigned(v) >> $urandom_range(0, 63);
         if ($urandom_range(0, 1)) v = -v;
      end else if (r < 9) begin
         v = 64'sd1;
         repeat ($urandom_range(0, 18)) v = v * 64'sd10;
         delta = int'($urandom_range(0, 2)) - 1;
         v = v + delta;
         if ($urandom_range(0, 1)) v = -v;
      end else begin
         case ($urandom_range(0, 3))
            0: v = VALUE_MIN;
            1: v = VALUE_MAX;
            2: v = 64'sd0;
            default: v = -64'sd1;
         endcase
      end
      return v;
   endfunction

   function automatic void report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.value <= '0;
         tx_gap = 0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (tx_gap != 0) begin
            tx_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_values.size() != 0) begin
            req_bus.valid <= 1'b1;
            req_bus.value <= pending_values.pop_front();
            tx_gap = pick_gap(tx_idle_on);
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response receiver, with one long hold-off once traffic is under way
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_gap    = 0;
         hold_left = 0;
      end else begin
         if (!hold_done && chars_received >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (rsp_bus.valid && rsp_bus.ready) rx_gap = pick_gap(rx_idle_on);
            if (rx_gap != 0) begin
               rx_gap--;
               rsp_bus.ready <= 1'b0;
            end else begin
               rsp_bus.ready <= 1'b1;
            end
         end
      end
   end

   // monitors
   always @(posedge clock) begin
      if (!reset && csr_bus.valid && csr_bus.ready) width_setting <= csr_bus.field_width;
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         requests_taken++;
         render_field(req_bus.value, width_setting);
      end
   end

   always @(posedge clock) begin
      field_char_type got;
      field_char_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         chars_received++;
         got = '{rsp_bus.char_code, rsp_bus.position, rsp_bus.last_char};
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected char: code %0d pos %0d last %0b",
                                      got.char_code, got.position, got.last_char));
         end else begin
            want = expected_chars.pop_front();
            if (got.char_code !== want.char_code || got.position !== want.position ||
                got.last_char !== want.last_char)
               report_mismatch($sformatf(
                  "char mismatch: exp code %0d pos %0d last %0b, got code %0d pos %0d last %0b",
                  want.char_code, want.position, want.last_char,
                  got.char_code, got.position, got.last_char));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic set_field_width(input logic [POS_W-1:0] w);
      @(posedge clock);
      csr_bus.valid       <= 1'b1;
      csr_bus.field_width <= w;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic queue_value(input logic signed [VALUE_W-1:0] v);
      pending_values.push_back(v);
      requests_issued++;
   endtask

   task automatic wait_drained();
      while (requests_taken != requests_issued || expected_chars.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      logic signed [VALUE_W-1:0] wide_set [$];
      logic signed [VALUE_W-1:0] narrow_set [$];
      logic [POS_W-1:0]          widths [$];
      csr_bus.valid       = 1'b0;
      csr_bus.field_width = '0;
      requests_issued     = 0;
      tx_idle_on          = 1'b0;
      rx_idle_on          = 1'b0;
      reset               = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wide_set = '{64'sd0, 64'sd1, -64'sd1, 64'sd9, -64'sd9, 64'sd10, -64'sd10,
                   VALUE_MAX, VALUE_MIN, VALUE_MIN + 64'sd1,
                   64'sd1000000000000000000, -64'sd99999999999999999};
      narrow_set = '{-64'sd12, -64'sd123, 64'sd999, 64'sd1000, 64'sd0, -64'sd1,
                     VALUE_MIN, 64'sd7};

      set_field_width(5'd20);
      foreach (wide_set[i]) queue_value(wide_set[i]);
      wait_drained();

      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      set_field_width(5'd3);
      foreach (narrow_set[i]) queue_value(narrow_set[i]);
      wait_drained();

      widths = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd20, 5'd21};
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         set_field_width((ph < widths.size()) ? widths[ph] : POS_W'($urandom_range(0, 31)));
         repeat (PHASE_ITEMS) queue_value(random_value());
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_chars.size() != 0)
         $display("%0d expected chars never arrived", expected_chars.size());
      if (mismatches == 0 && expected_chars.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
